>>> src/bps_pkg.sv
// Package for the byte pattern search unit: shared types, constants and the
// pattern byte selector. Used by the window cells, the top level and the checker.
package bps_pkg;

  localparam int unsigned MaxPatternDef = 16;
  localparam int unsigned PatBytes      = 16;
  localparam int unsigned CfgIdxW       = 2;
  localparam int unsigned LenW          = 5;

  typedef logic [7:0]             byte_t;
  typedef logic [8*PatBytes-1:0]  pattern_t;
  typedef logic [LenW-1:0]        len_t;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPatternLow    = 2'd0,
    CfgPatternHigh   = 2'd1,
    CfgPatternLength = 2'd2,
    CfgBaseOffset    = 2'd3
  } cfg_reg_e;

  // Control that every window cell sees in the same cycle.
  typedef struct packed {
    logic shift;  // an input beat is taken this cycle
    logic clear;  // the beat opens a new range
  } cell_ctrl_t;

  function automatic byte_t pat_byte(input pattern_t pat, input logic [3:0] idx);
    pat_byte = pat[idx*8 +: 8];
  endfunction

endpackage

>>> src/byte_pattern_search_unit.sv
// Byte pattern search unit: takes one byte per clock cycle unless stalled and
// reports the file offset of every leftmost, non-overlapping occurrence of a
// pattern of 1 to MAX_PATTERN bytes. A row of MAX_PATTERN-1 window cells holds
// the previous bytes and compares all of them in parallel with the incoming
// one, so a byte is accepted every unstalled cycle; the result is registered
// from the beat with the occurrence's last byte. A two-entry output stage
// keeps input flowing while a result waits. No clearing pass after reset.
module byte_pattern_search_unit #(
  parameter int unsigned MAX_PATTERN = bps_pkg::MaxPatternDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [bps_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [63:0]                  cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   data_byte_i,
  input  logic                         range_start_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [31:0]                  match_position_o
);
  import bps_pkg::*;

  localparam int unsigned NumCells = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;
  localparam len_t        MaxLen   = len_t'(MAX_PATTERN);
  localparam len_t        MaxRun   = len_t'(MAX_PATTERN - 1);

  // Configuration registers
  pattern_t    pattern_q;
  len_t        length_q;
  logic [31:0] base_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
      length_q  <= len_t'(1);
      base_q    <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CfgPatternLow:    pattern_q[63:0]   <= cfg_data_i;
        CfgPatternHigh:   pattern_q[127:64] <= cfg_data_i;
        CfgPatternLength: length_q          <= cfg_data_i[LenW-1:0];
        CfgBaseOffset:    base_q            <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // Input side
  logic        in_fire;
  logic        skid_valid_q;
  len_t        len_eff;
  len_t        run_q, run_d, run_eff;
  logic [31:0] idx_q, idx_eff;
  cell_ctrl_t  ctrl;

  assign in_stall_o = skid_valid_q;
  assign in_fire    = in_valid_i && !in_stall_o;
  // Shift in the upper bit, clear in the lower bit.
  assign ctrl       = cell_ctrl_t'({in_fire, range_start_i});

  assign len_eff = (length_q > MaxLen) ? MaxLen : length_q;
  assign run_eff = range_start_i ? '0 : run_q;
  assign idx_eff = range_start_i ? '0 : idx_q;

  // Window cells: cell k holds the byte k+1 places back and checks it
  // against pattern byte len-2-k while k+1 is below the pattern length.
  byte_t [NumCells-1:0] cell_byte;
  logic  [NumCells-1:0] cell_ok;

  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    byte_t      cell_in;
    logic [4:0] pat_idx;
    logic       active;

    assign pat_idx = len_eff - 5'd2 - 5'(k);
    assign active  = (5'(k) + 5'd1) < len_eff;

    if (k == 0) begin : g_first
      assign cell_in = data_byte_i;
    end else begin : g_next
      assign cell_in = cell_byte[k-1];
    end

    bps_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .byte_i     (cell_in),
      .pat_byte_i (pat_byte(pattern_q, pat_idx[3:0])),
      .active_i   (active),
      .byte_o     (cell_byte[k]),
      .ok_o       (cell_ok[k])
    );
  end

  logic        hit;
  logic [3:0]  last_idx;
  logic [31:0] pos;

  assign last_idx = 4'(len_eff - 5'd1);
  assign hit = (len_eff != '0)
            && (({1'b0, run_eff} + 6'd1) >= {1'b0, len_eff})
            && (pat_byte(pattern_q, last_idx) == data_byte_i)
            && (&cell_ok);
  assign pos = base_q + idx_eff - {27'd0, len_eff} + 32'd1;

  always_comb begin
    if (hit) begin
      run_d = '0;
    end else if (run_eff < MaxRun) begin
      run_d = run_eff + len_t'(1);
    end else begin
      run_d = run_eff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= '0;
      idx_q <= '0;
    end else if (in_fire) begin
      run_q <= run_d;
      idx_q <= idx_eff + 32'd1;
    end
  end

  // Output register with a skid entry behind it.
  logic        out_valid_q;
  logic [31:0] out_pos_q, skid_pos_q;
  logic        out_fire, hit_fire;

  assign out_fire = out_valid_q && !out_stall_i;
  assign hit_fire = in_fire && hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (hit_fire) begin
      if (!out_valid_q || out_fire) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_pos_q <= skid_pos_q;
      end
    end else if (hit_fire) begin
      if (!out_valid_q || out_fire) begin
        out_pos_q <= pos;
      end else begin
        skid_pos_q <= pos;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign match_position_o = out_pos_q;

endmodule

>>> src/bps_cell.sv
// One cell of the sliding byte window: holds one earlier byte, hands it on
// to its neighbour and compares it with its pattern byte. Depends on bps_pkg.
module bps_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bps_pkg::cell_ctrl_t ctrl_i,
  input  bps_pkg::byte_t     byte_i,
  input  bps_pkg::byte_t     pat_byte_i,
  input  logic               active_i,
  output bps_pkg::byte_t     byte_o,
  output logic               ok_o
);
  import bps_pkg::*;

  byte_t byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else if (ctrl_i.shift) begin
      byte_q <= byte_i;
    end
  end

  // A new range empties the window before the incoming byte is compared.
  assign byte_o = ctrl_i.clear ? '0 : byte_q;
  assign ok_o   = !active_i || (byte_o == pat_byte_i);

endmodule

>>> src/bps_checker.sv
// Port-level checks for the byte pattern search unit, bound to its top level.
// Depends on bps_pkg.
module bps_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [31:0]                 match_position_o
);
  import bps_pkg::*;

  // A held result stays on offer.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(match_position_o))
    else $error("stalled result changed");

  // The input is only held off when a result is already waiting in front.
  a_stall_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  // A new result needs an accepted byte in the cycle before.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && !(in_valid_i && !in_stall_o) |=> !out_valid_o)
    else $error("result appeared without an input beat");

endmodule

bind byte_pattern_search_unit bps_checker u_bps_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .match_position_o (match_position_o)
);
